@@ src/scc_pkg.sv @@
package scc_pkg;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_COMP    = 2'd2
  } status_e;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_F_ROOT,
    S_F_SCAN,
    S_F_WAIT,
    S_F_EDGE,
    S_R_POP,
    S_R_SCAN,
    S_R_WAIT,
    S_R_EDGE,
    S_OUT_RD,
    S_OUT_EMIT
  } state_e;

endpackage

@@ src/scc_ram.sv @@
module scc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ src/strongly_connected_components.sv @@
// Kosaraju strongly connected components, memory based sequencer.
// Add-edge word: status strobe follows accept through add_pend_q and then the strobe register; busy for one cycle.
// Run word: every frame rescans the E stored edges; after both passes a run over V
// vertices emits V results, one per vertex, each read from the component RAM.
// Results cannot be stalled by the receiver.
// Reset (async, active low) empties the edge store and sets vertex_count to 64.
module strongly_connected_components #(
  parameter int VERTICES = 64,
  parameter int EDGES    = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       opcode_i,
  input  logic [5:0] edge_source_i,
  input  logic [5:0] edge_target_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,
  output logic       strobe_o,
  output scc_pkg::status_e status_o,
  output logic [5:0] vertex_index_o,
  output logic [5:0] component_id_o,
  output logic       last_o
);
  import scc_pkg::*;

  localparam int EW = $clog2(EDGES);
  localparam int TW = $clog2(EDGES + 1);
  localparam int VW = $clog2(VERTICES);
  localparam int CW = $clog2(VERTICES + 1);

  state_e state_q, state_d;
  logic [6:0] vcount_q;
  logic [TW-1:0] total_q, total_d;
  logic [VERTICES-1:0] vis_q, vis_d;
  logic [CW-1:0] sp_q, sp_d, top_q, top_d;
  logic [VW-1:0] root_q, root_d, u_q, u_d;
  logic [TW-1:0] pos_q, pos_d;
  logic [5:0] comp_q, comp_d;
  logic [6:0] n;
  logic o_stb_q, o_stb_d, o_last_q, o_last_d;
  status_e o_st_q, o_st_d;
  logic [5:0] o_v_q, o_v_d, o_c_q, o_c_d;
  logic add_pend_q, add_pend_d;
  logic pend_st_q, pend_st_d;

  // edge RAM: {tail, head}
  logic e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [11:0] e_wdata, e_rdata;
  // stack RAM: {vertex, pos}
  logic s_we;
  logic [VW-1:0] s_waddr, s_raddr;
  logic [VW+TW-1:0] s_wdata, s_rdata;
  // finish stack RAM
  logic f_we;
  logic [VW-1:0] f_waddr, f_raddr;
  logic [VW-1:0] f_wdata, f_rdata;
  // component RAM
  logic c_we;
  logic [VW-1:0] c_waddr, c_raddr;
  logic [5:0] c_wdata, c_rdata;

  scc_ram #(.Width(12), .Depth(EDGES)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata));
  scc_ram #(.Width(VW+TW), .Depth(VERTICES)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata));
  scc_ram #(.Width(VW), .Depth(VERTICES)) u_fin (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata));
  scc_ram #(.Width(6), .Depth(VERTICES)) u_comp (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata));

  always_comb begin
    if (vcount_q == 7'd0) n = 7'd1;
    else if (vcount_q > 7'(VERTICES)) n = 7'(VERTICES);
    else n = vcount_q;
  end

  assign busy = (state_q != S_IDLE) || add_pend_q;
  assign cfg_ready_o = !busy;
  assign strobe_o = o_stb_q;
  assign status_o = o_st_q;
  assign vertex_index_o = o_v_q;
  assign component_id_o = o_c_q;
  assign last_o = o_last_q;

  logic [5:0] et, eh, w;
  logic e_ok, e_match, rev;
  always_comb begin
    et = e_rdata[11:6];
    eh = e_rdata[5:0];
    rev = (state_q == S_R_EDGE);
    e_ok = ({1'b0, et} < n) && ({1'b0, eh} < n);
    e_match = e_ok && ((rev ? eh : et) == 6'(u_q));
    w = rev ? et : eh;
  end

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    vis_d = vis_q;
    sp_d = sp_q;
    top_d = top_q;
    root_d = root_q;
    u_d = u_q;
    pos_d = pos_q;
    comp_d = comp_q;
    o_stb_d = 1'b0;
    o_st_d = o_st_q;
    o_v_d = o_v_q;
    o_c_d = o_c_q;
    o_last_d = 1'b0;
    add_pend_d = 1'b0;
    pend_st_d = pend_st_q;
    e_we = 1'b0;
    e_waddr = total_q[EW-1:0];
    e_wdata = {edge_source_i, edge_target_i};
    e_raddr = pos_q[EW-1:0];
    s_we = 1'b0;
    s_waddr = '0;
    s_wdata = {u_q, pos_q};
    s_raddr = '0;
    f_we = 1'b0;
    f_waddr = top_q[VW-1:0];
    f_wdata = u_q;
    f_raddr = '0;
    c_we = 1'b0;
    c_waddr = u_q;
    c_wdata = comp_q;
    c_raddr = root_q;

    if (add_pend_q) begin
      o_stb_d = 1'b1;
      o_st_d = pend_st_q ? ST_DROPPED : ST_ACCEPT;
      o_v_d = '0;
      o_c_d = '0;
      o_last_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (start && !add_pend_q) begin
          if (opcode_i == OP_ADD) begin
            add_pend_d = 1'b1;
            if (total_q < TW'(EDGES)) begin
              e_we = 1'b1;
              total_d = total_q + 1'b1;
              pend_st_d = 1'b0;
            end else begin
              pend_st_d = 1'b1;
            end
          end else begin
            // marks are all clear again when a run ends: the reverse pass
            // clears every vertex the forward pass marked
            top_d = '0;
            root_d = '0;
            state_d = S_F_ROOT;
          end
        end
      end
      S_F_ROOT: begin
        if ({1'b0, root_q} >= n) begin
          comp_d = '0;
          state_d = S_R_POP;
        end else if (vis_q[root_q]) begin
          root_d = root_q + 1'b1;
          if (32'(root_q) == VERTICES - 1) begin
            comp_d = '0;
            state_d = S_R_POP;
          end
        end else begin
          vis_d[root_q] = 1'b1;
          u_d = root_q;
          pos_d = '0;
          sp_d = CW'(1);
          state_d = S_F_SCAN;
        end
      end
      // scan: u_q/pos_q hold the top frame; read edge at pos
      S_F_SCAN, S_R_SCAN: begin
        if (pos_q >= total_q) begin
          // frame done: pop
          if (state_q == S_F_SCAN && top_q < CW'(VERTICES)) begin
            f_we = 1'b1;
            top_d = top_q + 1'b1;
          end
          sp_d = sp_q - 1'b1;
          if (sp_q == CW'(1)) begin
            if (state_q == S_F_SCAN) begin
              root_d = root_q + 1'b1;
              state_d = (32'(root_q) == VERTICES - 1) ? S_R_POP : S_F_ROOT;
              comp_d = '0;
            end else begin
              comp_d = comp_q + 1'b1;
              state_d = S_R_POP;
            end
          end else begin
            s_raddr = VW'(sp_q - CW'(2));
            state_d = (state_q == S_F_SCAN) ? S_F_WAIT : S_R_WAIT;
          end
        end else begin
          state_d = (state_q == S_F_SCAN) ? S_F_EDGE : S_R_EDGE;
        end
      end
      S_F_WAIT, S_R_WAIT: begin
        u_d = s_rdata[VW+TW-1:TW];
        pos_d = s_rdata[TW-1:0];
        state_d = (state_q == S_F_WAIT) ? S_F_SCAN : S_R_SCAN;
      end
      S_F_EDGE, S_R_EDGE: begin
        pos_d = pos_q + 1'b1;
        state_d = (state_q == S_F_EDGE) ? S_F_SCAN : S_R_SCAN;
        if (e_match && (vis_q[w[VW-1:0]] == rev) && sp_q < CW'(VERTICES)) begin
          // push current frame with advanced position, descend into w
          s_we = 1'b1;
          s_waddr = VW'(sp_q - CW'(1));
          s_wdata = {u_q, TW'(pos_q + 1'b1)};
          vis_d[w[VW-1:0]] = !rev;
          if (rev) begin
            c_we = 1'b1;
            c_waddr = w[VW-1:0];
          end
          u_d = w[VW-1:0];
          pos_d = '0;
          sp_d = sp_q + 1'b1;
        end
      end
      S_R_POP: begin
        if (top_q == '0) begin
          root_d = '0;
          state_d = S_OUT_RD;
        end else begin
          f_raddr = VW'(top_q - 1'b1);
          top_d = top_q - 1'b1;
          // wait for the finish-stack read in R_WAIT, handled by the root stage below
          state_d = S_R_WAIT;
          sp_d = '0;
        end
      end
      S_OUT_RD: begin
        c_raddr = root_q;
        state_d = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        o_stb_d = 1'b1;
        o_st_d = ST_COMP;
        o_v_d = 6'(root_q);
        o_c_d = c_rdata;
        o_last_d = ({1'b0, root_q} + 7'd1 == n);
        root_d = root_q + 1'b1;
        if ({1'b0, root_q} + 7'd1 == n) begin
          total_d = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // finish-stack pop lands in R_WAIT with sp==0: start a reverse root if still marked
    if (state_q == S_R_WAIT && sp_q == '0) begin
      state_d = S_R_POP;
      if ({1'b0, f_rdata} < n && vis_q[f_rdata]) begin
        vis_d[f_rdata] = 1'b0;
        c_we = 1'b1;
        c_waddr = f_rdata;
        u_d = f_rdata;
        pos_d = '0;
        sp_d = CW'(1);
        state_d = S_R_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcount_q <= 7'd64;
      total_q <= '0;
      vis_q <= '0;
      sp_q <= '0;
      top_q <= '0;
      root_q <= '0;
      comp_q <= '0;
      o_stb_q <= 1'b0;
      add_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) vcount_q <= cfg_data_i;
      total_q <= total_d;
      vis_q <= vis_d;
      sp_q <= sp_d;
      top_q <= top_d;
      root_q <= root_d;
      comp_q <= comp_d;
      o_stb_q <= o_stb_d;
      add_pend_q <= add_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    pos_q <= pos_d;
    o_st_q <= o_st_d;
    o_v_q <= o_v_d;
    o_c_q <= o_c_d;
    o_last_q <= o_last_d;
    pend_st_q <= pend_st_d;
  end
endmodule
